[src/graph_color_refinement_defines.svh]
// Assertion macros for the color refinement block.
`ifndef GRAPH_COLOR_REFINEMENT_DEFINES_SVH
`define GRAPH_COLOR_REFINEMENT_DEFINES_SVH

// same-cycle implication, held off during reset
`define GCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define GCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset
`define GCR_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[src/gcr_pkg.sv]
`default_nettype none
package gcr_pkg;

  localparam int OPCODE_W      = 2;
  localparam int NODE_W        = 8;
  localparam int CLASS_OUT_W   = 8;
  localparam int COUNT_W       = 9;
  localparam int STATUS_W      = 2;
  localparam int DEF_MAX_NODES = 256;
  localparam int DEF_MAX_EDGES = 1024;
  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 9'd256;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_INIT,
    ST_ROUND,
    ST_CLEAR,
    ST_EDGE_RD,
    ST_EDGE_CLS,
    ST_EDGE_CNT,
    ST_EDGE_WR,
    ST_CLASS,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_VEC_RD,
    ST_VEC_EV
  } state_t;

endpackage
`default_nettype wire

[src/gcr_count_ram.sv]
`default_nettype none
module gcr_count_ram #(
  parameter int AW = 16,
  parameter int DW = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [DW-1:0] rdata_a,
  output logic      [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [1 << AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

[src/graph_color_refinement.sv]
// Channel   Signals                                  Direction
// in        in_valid/in_ready, opcode/src/dst_node   into block
// out       out_valid/out_ready, node_class,
//           class_count, status                      out of block
// cfg       cfg_valid/cfg_ready, cfg_data            into block
//
// Load, clear, out-of-range ops answer from idle. Read: via the class store port.
// Run: clears all MAX_NODES entries of the class store, then per round n*k count
// clears, one count update per counted edge, and two scans of n nodes for each
// group found plus one more per class, comparing vector entries one by one.
// After reset a clearing pass sweeps all MAX_NODES entries of the class store.
// The input stalls while the output register holds an untaken result.
`default_nettype none
module graph_color_refinement #(
  parameter int MAX_NODES = gcr_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = gcr_pkg::DEF_MAX_EDGES
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [gcr_pkg::OPCODE_W-1:0]     opcode,
  input  wire logic [gcr_pkg::NODE_W-1:0]       src_node,
  input  wire logic [gcr_pkg::NODE_W-1:0]       dst_node,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [gcr_pkg::CLASS_OUT_W-1:0]  node_class,
  output logic      [gcr_pkg::COUNT_W-1:0]      class_count,
  output logic      [gcr_pkg::STATUS_W-1:0]     status,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [gcr_pkg::COUNT_W-1:0]      cfg_data
);
  import gcr_pkg::*;

  localparam int NW   = $clog2(MAX_NODES);
  localparam int KW   = NW + 1;
  localparam int CAW  = 2 * NW;
  localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ELW  = $clog2(MAX_EDGES + 1);
  localparam int CNTW = $clog2(MAX_EDGES + 1);

  state_t state, state_next;
  logic [COUNT_W-1:0] node_count;
  logic [ELW-1:0]     edges_loaded, edges_next;
  logic [KW-1:0]      k, k_next, newk, newk_next, kuse, kuse_next;
  logic [KW-1:0]      ci, ci_next, v, v_next, c, c_next;
  logic [ELW-1:0]     e, e_next;
  logic [NW-1:0]      best, best_next;
  logic               has_best, has_best_next, first_grp, first_next;
  logic               label_mode, label_mode_next, boot, boot_next;
  logic [CAW-1:0]     cnt_addr, cnt_addr_next;
  logic [MAX_NODES-1:0] done;
  logic               done_clr, done_set;

  logic               out_load;
  logic [CLASS_OUT_W-1:0] out_cls_next;
  stat_t              out_stat_next;

  logic [NW-1:0] cls_mem [MAX_NODES];
  logic          cls_we, cls_re;
  logic [NW-1:0] cls_waddr, cls_wdata, cls_raddr, cls_q;

  logic [NODE_W-1:0] esrc_mem [MAX_EDGES];
  logic [NODE_W-1:0] edst_mem [MAX_EDGES];
  logic              edge_we, edge_re;
  logic [EAW-1:0]    edge_raddr;
  logic [NODE_W-1:0] esrc_q, edst_q;

  logic            cnt_we, cnt_re;
  logic [CAW-1:0]  cnt_waddr, cnt_raddr_a, cnt_raddr_b;
  logic [CNTW-1:0] cnt_wdata, cnt_qa, cnt_qb;

  logic [KW-1:0] n_act;
  logic [NW-1:0] v_idx, c_idx, label;
  logic          src_ok, dst_ok, esrc_ok, edst_ok, accept;

  assign cfg_ready = 1'b1;
  assign v_idx = v[NW-1:0];
  assign c_idx = c[NW-1:0];
  assign label = first_grp ? ci[NW-1:0] : newk[NW-1:0];

  always_comb begin
    if (node_count == '0) begin
      n_act = KW'(1);
    end else if (32'(node_count) > MAX_NODES) begin
      n_act = KW'(MAX_NODES);
    end else begin
      n_act = KW'(node_count);
    end
  end

  assign src_ok  = 32'(src_node) < 32'(n_act);
  assign dst_ok  = 32'(dst_node) < 32'(n_act);
  assign esrc_ok = 32'(esrc_q) < 32'(n_act);
  assign edst_ok = 32'(edst_q) < 32'(n_act);

  always_ff @(posedge clk) begin
    if (cls_we) begin
      cls_mem[cls_waddr] <= cls_wdata;
    end
    if (cls_re) begin
      cls_q <= cls_mem[cls_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      esrc_mem[edges_loaded[EAW-1:0]] <= src_node;
      edst_mem[edges_loaded[EAW-1:0]] <= dst_node;
    end
    if (edge_re) begin
      esrc_q <= esrc_mem[edge_raddr];
      edst_q <= edst_mem[edge_raddr];
    end
  end

  gcr_count_ram #(
    .AW(CAW),
    .DW(CNTW)
  ) u_count_ram (
    .clk     (clk),
    .we      (cnt_we),
    .waddr   (cnt_waddr),
    .wdata   (cnt_wdata),
    .re      (cnt_re),
    .raddr_a (cnt_raddr_a),
    .raddr_b (cnt_raddr_b),
    .rdata_a (cnt_qa),
    .rdata_b (cnt_qb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      boot         <= 1'b1;
      v            <= '0;
      node_count   <= NODE_COUNT_RESET;
      edges_loaded <= '0;
      kuse         <= KW'(1);
      out_valid    <= 1'b0;
      done         <= '0;
    end else begin
      state        <= state_next;
      boot         <= boot_next;
      v            <= v_next;
      edges_loaded <= edges_next;
      kuse         <= kuse_next;
      if (cfg_valid) begin
        node_count <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (done_clr) begin
        done <= '0;
      end else if (done_set) begin
        done[v_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    k          <= k_next;
    newk       <= newk_next;
    ci         <= ci_next;
    c          <= c_next;
    e          <= e_next;
    best       <= best_next;
    has_best   <= has_best_next;
    first_grp  <= first_next;
    label_mode <= label_mode_next;
    cnt_addr   <= cnt_addr_next;
    if (out_load) begin
      node_class  <= out_cls_next;
      class_count <= COUNT_W'(kuse_next);
      status      <= out_stat_next;
    end
  end

  always_comb begin
    state_next      = state;
    boot_next       = boot;
    v_next          = v;
    c_next          = c;
    e_next          = e;
    ci_next         = ci;
    k_next          = k;
    newk_next       = newk;
    kuse_next       = kuse;
    best_next       = best;
    has_best_next   = has_best;
    first_next      = first_grp;
    label_mode_next = label_mode;
    edges_next      = edges_loaded;
    cnt_addr_next   = cnt_addr;
    in_ready        = 1'b0;
    accept          = 1'b0;
    out_load        = 1'b0;
    out_cls_next    = '0;
    out_stat_next   = STAT_OK;
    cls_we          = 1'b0;
    cls_waddr       = v_idx;
    cls_wdata       = '0;
    cls_re          = 1'b0;
    cls_raddr       = v_idx;
    edge_we         = 1'b0;
    edge_re         = 1'b0;
    edge_raddr      = e[EAW-1:0];
    cnt_we          = 1'b0;
    cnt_waddr       = cnt_addr;
    cnt_wdata       = '0;
    cnt_re          = 1'b0;
    cnt_raddr_a     = {v_idx, c_idx};
    cnt_raddr_b     = {best, c_idx};
    done_clr        = 1'b0;
    done_set        = 1'b0;

    case (state)
      ST_IDLE: begin
        in_ready = !out_valid || out_ready;
        accept   = in_valid && in_ready;
        if (accept) begin
          case (op_t'(opcode))
            OP_LOAD: begin
              out_load = 1'b1;
              if (edges_loaded == ELW'(MAX_EDGES)) begin
                out_stat_next = STAT_FULL;
              end else if (!src_ok || !dst_ok) begin
                out_stat_next = STAT_RANGE;
              end else begin
                edge_we    = 1'b1;
                edges_next = edges_loaded + ELW'(1);
              end
            end
            OP_RUN: begin
              v_next     = '0;
              state_next = ST_INIT;
            end
            OP_READ: begin
              if (!src_ok) begin
                out_load      = 1'b1;
                out_stat_next = STAT_RANGE;
              end else begin
                cls_re     = 1'b1;
                cls_raddr  = NW'(src_node);
                state_next = ST_READ;
              end
            end
            OP_CLEAR: begin
              out_load   = 1'b1;
              edges_next = '0;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        out_load     = 1'b1;
        out_cls_next = CLASS_OUT_W'(cls_q);
        state_next   = ST_IDLE;
      end
      ST_INIT: begin
        cls_we = 1'b1;
        v_next = v + KW'(1);
        if (v == KW'(MAX_NODES - 1)) begin
          boot_next = 1'b0;
          k_next    = KW'(1);
          if (boot) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        done_clr   = 1'b1;
        newk_next  = k;
        v_next     = '0;
        c_next     = '0;
        state_next = ST_CLEAR;
      end
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = {v_idx, c_idx};
        if (c + KW'(1) == k) begin
          c_next = '0;
          if (v + KW'(1) == n_act) begin
            e_next     = '0;
            state_next = ST_EDGE_RD;
          end else begin
            v_next = v + KW'(1);
          end
        end else begin
          c_next = c + KW'(1);
        end
      end
      ST_EDGE_RD: begin
        if (e == edges_loaded) begin
          ci_next    = '0;
          state_next = ST_CLASS;
        end else begin
          edge_re    = 1'b1;
          state_next = ST_EDGE_CLS;
        end
      end
      ST_EDGE_CLS: begin
        if (esrc_ok && edst_ok) begin
          cls_re     = 1'b1;
          cls_raddr  = NW'(esrc_q);
          state_next = ST_EDGE_CNT;
        end else begin
          e_next     = e + ELW'(1);
          state_next = ST_EDGE_RD;
        end
      end
      ST_EDGE_CNT: begin
        if (KW'(cls_q) < k) begin
          cnt_re        = 1'b1;
          cnt_raddr_a   = {NW'(edst_q), cls_q};
          cnt_addr_next = {NW'(edst_q), cls_q};
          state_next    = ST_EDGE_WR;
        end else begin
          e_next     = e + ELW'(1);
          state_next = ST_EDGE_RD;
        end
      end
      ST_EDGE_WR: begin
        cnt_we     = 1'b1;
        cnt_wdata  = cnt_qa + CNTW'(1);
        e_next     = e + ELW'(1);
        state_next = ST_EDGE_RD;
      end
      ST_CLASS: begin
        if (ci == k) begin
          if (newk == k) begin
            kuse_next  = k;
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            k_next     = newk;
            state_next = ST_ROUND;
          end
        end else begin
          first_next      = 1'b1;
          has_best_next   = 1'b0;
          label_mode_next = 1'b0;
          v_next          = '0;
          state_next      = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (v == n_act) begin
          v_next = '0;
          if (!label_mode) begin
            if (!has_best) begin
              ci_next    = ci + KW'(1);
              state_next = ST_CLASS;
            end else begin
              label_mode_next = 1'b1;
            end
          end else begin
            if (!first_grp) begin
              newk_next = newk + KW'(1);
            end
            first_next      = 1'b0;
            has_best_next   = 1'b0;
            label_mode_next = 1'b0;
          end
        end else begin
          cls_re     = 1'b1;
          state_next = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if ((KW'(cls_q) == ci) && !done[v_idx]) begin
          if (!label_mode && !has_best) begin
            best_next     = v_idx;
            has_best_next = 1'b1;
            v_next        = v + KW'(1);
            state_next    = ST_SCAN_RD;
          end else begin
            c_next     = '0;
            state_next = ST_VEC_RD;
          end
        end else begin
          v_next     = v + KW'(1);
          state_next = ST_SCAN_RD;
        end
      end
      ST_VEC_RD: begin
        cnt_re     = 1'b1;
        state_next = ST_VEC_EV;
      end
      ST_VEC_EV: begin
        if (cnt_qa != cnt_qb) begin
          if (!label_mode && (cnt_qa < cnt_qb)) begin
            best_next = v_idx;
          end
          v_next     = v + KW'(1);
          state_next = ST_SCAN_RD;
        end else if (c + KW'(1) == k) begin
          if (label_mode) begin
            cls_we    = 1'b1;
            cls_wdata = label;
            done_set  = 1'b1;
          end
          v_next     = v + KW'(1);
          state_next = ST_SCAN_RD;
        end else begin
          c_next     = c + KW'(1);
          state_next = ST_VEC_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/gcr_checker.sv]
`default_nettype none
`include "graph_color_refinement_defines.svh"
module gcr_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic [gcr_pkg::OPCODE_W-1:0]     opcode,
  input wire logic [gcr_pkg::NODE_W-1:0]       src_node,
  input wire logic [gcr_pkg::NODE_W-1:0]       dst_node,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [gcr_pkg::CLASS_OUT_W-1:0]  node_class,
  input wire logic [gcr_pkg::COUNT_W-1:0]      class_count,
  input wire logic [gcr_pkg::STATUS_W-1:0]     status,
  input wire logic                             cfg_valid,
  input wire logic                             cfg_ready,
  input wire logic [gcr_pkg::COUNT_W-1:0]      cfg_data
);
  import gcr_pkg::*;

  `GCR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(node_class) && $stable(class_count) && $stable(status), "result changed while stalled")
  `GCR_ASSERT_NOW(a_class_range, out_valid, (class_count != 0) && (node_class < class_count), "node class not below class count")
  `GCR_ASSERT_NEXT(a_run_busy, in_valid && in_ready && (opcode == OP_RUN), !in_ready, "input taken right after run")
  `GCR_ASSERT_RST(a_rst_quiet, rst, !out_valid && !in_ready, "block active right after reset")

endmodule

bind graph_color_refinement gcr_checker u_gcr_checker (.*);
`default_nettype wire
